@@ sv/zba_pkg.sv @@
// Shared types, codes and constants of the zone block allocator.
`default_nettype none
package zba_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 64;
	localparam int unsigned HEAP_BYTES     = 33554432;
	localparam int unsigned HEADER_BYTES   = 24;

	localparam int ACT_W   = 3;
	localparam int SIZE_W  = 26;
	localparam int TAG_W   = 8;
	localparam int OWN_W   = 16;
	localparam int ADDR_W  = 25;
	localparam int LEN_W   = 26;
	localparam int BS_W    = 27;
	localparam int ST_W    = 2;
	localparam int NRES_W  = 6;
	localparam int CFG_I_W = 1;

	localparam logic [LEN_W-1:0]  HEAP_LEN   = LEN_W'(HEAP_BYTES);
	localparam logic [BS_W-1:0]   ALIGN_MASK = ~BS_W'(3);
	localparam logic [NRES_W-1:0] MAX_NOTES  = NRES_W'(63);

	localparam logic [TAG_W-1:0] PURGE_RST = 8'd100;
	localparam logic [TAG_W-1:0] SUB_RST   = 8'd1;

	localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CHANGE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RANGE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REPORT = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_OOM   = 2'd1;
	localparam logic [ST_W-1:0] ST_OWNER = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

	localparam logic [CFG_I_W-1:0] CFG_PURGE = 1'b0;
	localparam logic [CFG_I_W-1:0] CFG_SUB   = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
		logic [TAG_W-1:0]  tag;
		logic [OWN_W-1:0]  owner;
	} entry_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic              notice;
		logic [OWN_W-1:0]  cleared_owner;
		logic [ADDR_W-1:0] data_address;
		logic [LEN_W-1:0]  free_bytes;
		logic [LEN_W-1:0]  cache_bytes;
		logic [LEN_W-1:0]  used_bytes;
		logic [LEN_W-1:0]  largest_run;
		logic              last;
	} result_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_REPLY, S_NOTE,
		S_FIND_RD, S_FIND_CHK, S_REP_RD, S_REP_ACC, S_RNG_RD, S_RNG_CHK,
		S_FB_RD, S_FB_CLR, S_FB_PREV, S_FB_NRD, S_FB_NXT, S_FB_RET,
		S_SH_DN, S_SH_UP,
		S_A_INIT, S_A_PREV, S_A_SKIP, S_A_SKIP_CHK, S_A_RUN, S_A_RUN_CHK,
		S_A_BASE_RD, S_A_BASE_CHK, S_A_PL_RD, S_A_PL_LEN, S_A_PL_NXT,
		S_A_SET, S_A_DONE
	} state_t;

	typedef enum logic [1:0] {RET_PURGE, RET_SPLIT, RET_FREE, RET_RANGE} fb_ret_t;

	function automatic logic [TAG_W-1:0] eff_sub(input logic [TAG_W-1:0] s);
		return (s == '0) ? TAG_W'(1) : s;
	endfunction

	function automatic logic is_blocker(input logic [TAG_W-1:0] t, input logic [TAG_W-1:0] pl);
		return (t != '0) && (t < pl);
	endfunction

endpackage
`default_nettype wire

@@ sv/zone_block_allocator_top.sv @@
// Zone block allocator: address-ordered block table with a rover first-fit search.
//
// Requests enter on in_valid/in_ready and each gives one or more result items on
// out_valid/out_ready. Owner-cleared notices (notice 1, last 0) come first and the
// final reply (last 1) closes the request. One request is worked at a time; in_ready
// stays low from acceptance until the final reply sits in the output register.
// All work goes through one table memory with a single registered read port and one
// write port, stepped by a sequencer:
//   report, free tag range, find: walk the table entry by entry;
//   merging or splitting a block moves the tail of the table, entry by entry;
//   alloc: a search over the table entries, plus the table moves for each purged or
//   split block.
// Results wait in the output register while the receiver stalls, and the sequencer
// holds until that register frees up.
// After reset the table holds one free block spanning the heap; no request is accepted
// while that entry is seeded. Configuration writes on
// cfg_write are taken at any edge and must only be issued while the block is idle.
`default_nettype none
module zone_block_allocator_top #(
	parameter int MAX_BLOCKS = zba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [zba_pkg::ACT_W-1:0]   action,
	input  logic [zba_pkg::SIZE_W-1:0]  size_bytes,
	input  logic [zba_pkg::TAG_W-1:0]   tag,
	input  logic [zba_pkg::TAG_W-1:0]   high_tag,
	input  logic [zba_pkg::OWN_W-1:0]   owner,
	input  logic [zba_pkg::ADDR_W-1:0]  address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [zba_pkg::ST_W-1:0]    status,
	output logic                        notice,
	output logic [zba_pkg::OWN_W-1:0]   cleared_owner,
	output logic [zba_pkg::ADDR_W-1:0]  data_address,
	output logic [zba_pkg::LEN_W-1:0]   free_bytes,
	output logic [zba_pkg::LEN_W-1:0]   cache_bytes,
	output logic [zba_pkg::LEN_W-1:0]   used_bytes,
	output logic [zba_pkg::LEN_W-1:0]   largest_run,
	output logic                        last,
	input  logic                        cfg_write,
	input  logic [zba_pkg::CFG_I_W-1:0] cfg_index,
	input  logic [zba_pkg::TAG_W-1:0]   cfg_data
);
	import zba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] TWO     = CW'(2);

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [TAG_W-1:0]  tag;
		logic [TAG_W-1:0]  hi;
		logic [OWN_W-1:0]  own;
		logic [ADDR_W-1:0] addr;
		logic [BS_W-1:0]   bs;
		logic [CW-1:0]     idx;
		logic [CW-1:0]     base;
		logic [CW-1:0]     stop;
		logic [CW-1:0]     r;
		logic [BS_W-1:0]   space;
		logic              finish;
		logic [CW-1:0]     fi;
		fb_ret_t           fret;
		state_t            sret;
		logic [CW-1:0]     ptr;
		logic              pend;
		logic [CW-1:0]     j;
		entry_t            cur;
		entry_t            nent;
		logic [OWN_W-1:0]  note_own;
		logic [NRES_W-1:0] nres;
		logic [ST_W-1:0]   rst;
		logic [OWN_W-1:0]  rown;
		logic [ADDR_W-1:0] radr;
		logic [LEN_W-1:0]  fb;
		logic [LEN_W-1:0]  cb;
		logic [LEN_W-1:0]  ub;
		logic [LEN_W-1:0]  run;
		logic [LEN_W-1:0]  best;
	} ctx_t;

	state_t  state_q, state_d;
	ctx_t    c_q, c_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rover_q, rover_d;
	result_t out_q, out_d;
	logic    out_valid_q, out_valid_d;
	logic [TAG_W-1:0] purge_q, sub_q;

	entry_t  mem [MAX_BLOCKS];
	entry_t  rd_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic    wr_en;
	entry_t  wr_data;
	logic    slot_free;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			purge_q <= PURGE_RST;
			sub_q   <= SUB_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PURGE: purge_q <= cfg_data;
				CFG_SUB:   sub_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			c_q         <= '0;
			count_q     <= ONE;
			rover_q     <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			c_q         <= c_d;
			count_q     <= count_d;
			rover_q     <= rover_d;
			out_q       <= out_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin : p_fsm
		entry_t e;
		logic [CW-1:0] b;
		logic [LEN_W-1:0] run_n;
		logic [LEN_W-1:0] extra;
		logic fin;
		state_d     = state_q;
		c_d         = c_q;
		count_d     = count_q;
		rover_d     = rover_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = c_q.cur;
		e           = rd_q;
		b           = c_q.base;
		run_n       = c_q.run;
		extra       = '0;
		fin         = c_q.finish;

		unique case (state_q)
			S_INIT: begin
				// seed the single free block that spans the heap
				wr_en   = 1'b1;
				wr_data = '{start: '0, len: HEAP_LEN, tag: '0, owner: '0};
				state_d = S_IDLE;
			end

			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					c_d.act    = action;
					c_d.tag    = tag;
					c_d.hi     = high_tag;
					c_d.own    = owner;
					c_d.addr   = address;
					c_d.bs     = ((BS_W'(size_bytes) + BS_W'(3)) & ALIGN_MASK)
						+ BS_W'(HEADER_BYTES);
					c_d.idx    = '0;
					c_d.finish = 1'b0;
					c_d.nres   = '0;
					c_d.rst    = ST_OK;
					c_d.rown   = '0;
					c_d.radr   = '0;
					c_d.fb     = '0;
					c_d.cb     = '0;
					c_d.ub     = '0;
					c_d.run    = '0;
					c_d.best   = '0;
					unique case (action)
						ACT_ALLOC: begin
							if (tag != '0 && tag >= purge_q && owner == '0) begin
								c_d.rst = ST_OWNER;
								state_d = S_REPLY;
							end else begin
								state_d = S_A_INIT;
							end
						end
						ACT_FREE, ACT_CHANGE: state_d = S_FIND_RD;
						ACT_RANGE:            state_d = S_RNG_RD;
						ACT_REPORT:           state_d = S_REP_RD;
						default:              state_d = S_REPLY;
					endcase
				end
			end

			S_REPLY: begin
				if (slot_free) begin
					out_d = '{status: c_q.rst, notice: 1'b0, cleared_owner: c_q.rown,
						data_address: c_q.radr, free_bytes: c_q.fb, cache_bytes: c_q.cb,
						used_bytes: c_q.ub, largest_run: c_q.best, last: 1'b1};
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end

			S_NOTE: begin
				// past the notice budget, keep only the latest owner for the reply
				if (c_q.note_own == '0) begin
					state_d = S_FB_RD;
				end else if (c_q.nres == MAX_NOTES) begin
					c_d.rown = c_q.note_own;
					state_d  = S_FB_RD;
				end else if (slot_free) begin
					out_d = '{status: ST_OK, notice: 1'b1, cleared_owner: c_q.note_own,
						data_address: '0, free_bytes: '0, cache_bytes: '0,
						used_bytes: '0, largest_run: '0, last: 1'b0};
					out_valid_d = 1'b1;
					c_d.nres    = c_q.nres + NRES_W'(1);
					state_d     = S_FB_RD;
				end
			end

			S_FIND_RD: begin
				if (c_q.idx < count_q) begin
					rd_addr = c_q.idx[IW-1:0];
					state_d = S_FIND_CHK;
				end else begin
					c_d.rst = ST_BAD;
					state_d = S_REPLY;
				end
			end

			S_FIND_CHK: begin
				if (e.tag != '0
						&& ({1'b0, e.start} + LEN_W'(HEADER_BYTES)) == {1'b0, c_q.addr}) begin
					if (c_q.act == ACT_FREE) begin
						c_d.rown = e.owner;
						c_d.fi   = c_q.idx;
						c_d.fret = RET_FREE;
						state_d  = S_FB_RD;
					end else if (c_q.tag != '0 && c_q.tag >= purge_q && e.owner == '0) begin
						c_d.rst = ST_OWNER;
						state_d = S_REPLY;
					end else begin
						e.tag   = (c_q.tag == '0) ? eff_sub(sub_q) : c_q.tag;
						wr_en   = 1'b1;
						wr_addr = c_q.idx[IW-1:0];
						wr_data = e;
						state_d = S_REPLY;
					end
				end else begin
					c_d.idx = c_q.idx + ONE;
					state_d = S_FIND_RD;
				end
			end

			S_REP_RD: begin
				if (c_q.idx < count_q) begin
					rd_addr = c_q.idx[IW-1:0];
					state_d = S_REP_ACC;
				end else begin
					state_d = S_REPLY;
				end
			end

			S_REP_ACC: begin
				if (e.tag == '0) begin
					c_d.fb = c_q.fb + e.len;
					run_n  = c_q.run + e.len;
				end else if (e.tag >= purge_q) begin
					c_d.cb = c_q.cb + e.len;
					run_n  = c_q.run + e.len;
				end else begin
					c_d.ub = c_q.ub + e.len;
					run_n  = '0;
				end
				c_d.run = run_n;
				if (run_n > c_q.best) begin
					c_d.best = run_n;
				end
				c_d.idx = c_q.idx + ONE;
				state_d = S_REP_RD;
			end

			S_RNG_RD: begin
				if (c_q.idx < count_q) begin
					rd_addr = c_q.idx[IW-1:0];
					state_d = S_RNG_CHK;
				end else begin
					c_d.rown = c_q.rown;
					state_d  = S_REPLY;
				end
			end

			S_RNG_CHK: begin
				if (e.tag != '0 && e.tag >= c_q.tag && e.tag <= c_q.hi) begin
					c_d.note_own = e.owner;
					c_d.fi       = c_q.idx;
					c_d.fret     = RET_RANGE;
					state_d      = S_NOTE;
				end else begin
					c_d.idx = c_q.idx + ONE;
					state_d = S_RNG_RD;
				end
			end

			S_FB_RD: begin
				rd_addr = c_q.fi[IW-1:0];
				state_d = S_FB_CLR;
			end

			S_FB_CLR: begin
				e.tag   = '0;
				e.owner = '0;
				wr_en   = 1'b1;
				wr_addr = c_q.fi[IW-1:0];
				wr_data = e;
				c_d.cur = e;
				if (c_q.fi != '0) begin
					rd_addr = IW'(c_q.fi - ONE);
					state_d = S_FB_PREV;
				end else begin
					state_d = S_FB_NRD;
				end
			end

			S_FB_PREV: begin
				if (e.tag == '0) begin
					// fold this block into the free one before it
					e.len    = e.len + c_q.cur.len;
					wr_en    = 1'b1;
					wr_addr  = IW'(c_q.fi - ONE);
					wr_data  = e;
					c_d.cur  = e;
					c_d.j    = c_q.fi;
					c_d.ptr  = c_q.fi + ONE;
					c_d.pend = 1'b0;
					c_d.fi   = c_q.fi - ONE;
					c_d.sret = S_FB_NRD;
					state_d  = S_SH_DN;
				end else begin
					state_d = S_FB_NRD;
				end
			end

			S_FB_NRD: begin
				if (c_q.fi + ONE < count_q) begin
					rd_addr = IW'(c_q.fi + ONE);
					state_d = S_FB_NXT;
				end else begin
					state_d = S_FB_RET;
				end
			end

			S_FB_NXT: begin
				if (e.tag == '0) begin
					c_d.cur.len = c_q.cur.len + e.len;
					wr_en       = 1'b1;
					wr_addr     = c_q.fi[IW-1:0];
					wr_data     = c_d.cur;
					c_d.j       = c_q.fi + ONE;
					c_d.ptr     = c_q.fi + TWO;
					c_d.pend    = 1'b0;
					c_d.sret    = S_FB_RET;
					state_d     = S_SH_DN;
				end else begin
					state_d = S_FB_RET;
				end
			end

			S_FB_RET: begin
				unique case (c_q.fret)
					RET_PURGE: begin
						c_d.base = c_q.fi;
						state_d  = S_A_PL_RD;
					end
					RET_SPLIT: state_d = S_A_DONE;
					RET_FREE:  state_d = S_REPLY;
					RET_RANGE: begin
						c_d.idx = c_q.fi + ONE;
						state_d = S_RNG_RD;
					end
				endcase
			end

			S_SH_DN: begin
				// close the gap at j: read one entry ahead, write it one place down
				if (c_q.pend) begin
					wr_en   = 1'b1;
					wr_addr = IW'(c_q.ptr - TWO);
					wr_data = rd_q;
				end
				if (c_q.ptr < count_q) begin
					rd_addr  = c_q.ptr[IW-1:0];
					c_d.ptr  = c_q.ptr + ONE;
					c_d.pend = 1'b1;
				end else begin
					c_d.pend = 1'b0;
				end
				if (!c_q.pend && c_q.ptr >= count_q) begin
					count_d = count_q - ONE;
					if (rover_q >= c_q.j) begin
						rover_d = rover_q - ONE;
					end
					state_d = c_q.sret;
				end
			end

			S_SH_UP: begin
				// open a gap at j, moving the tail up from the top
				if (c_q.pend) begin
					wr_en   = 1'b1;
					wr_addr = IW'(c_q.ptr + ONE);
					wr_data = rd_q;
				end
				if (c_q.ptr > c_q.j) begin
					rd_addr  = IW'(c_q.ptr - ONE);
					c_d.ptr  = c_q.ptr - ONE;
					c_d.pend = 1'b1;
				end else begin
					c_d.pend = 1'b0;
				end
				if (!c_q.pend && c_q.ptr <= c_q.j) begin
					wr_en   = 1'b1;
					wr_addr = c_q.j[IW-1:0];
					wr_data = c_q.nent;
					count_d = count_q + ONE;
					if (rover_q >= c_q.j) begin
						rover_d = rover_q + ONE;
					end
					c_d.fi   = c_q.j;
					c_d.fret = RET_SPLIT;
					state_d  = S_FB_RD;
				end
			end

			S_A_INIT: begin
				b = (rover_q > count_q) ? count_q : rover_q;
				c_d.base = b;
				if (b != '0) begin
					rd_addr = IW'(b - ONE);
					state_d = S_A_PREV;
				end else begin
					c_d.stop = count_q;
					state_d  = S_A_SKIP;
				end
			end

			S_A_PREV: begin
				// step back to the block just behind the rover if that block is free
				if (e.tag == '0) begin
					b = c_q.base - ONE;
				end
				c_d.base = b;
				c_d.stop = (b == '0) ? count_q : b - ONE;
				state_d  = S_A_SKIP;
			end

			S_A_SKIP: begin
				if (c_q.base == c_q.stop) begin
					c_d.rst = ST_OOM;
					state_d = S_REPLY;
				end else if (c_q.base >= count_q) begin
					c_d.base = '0;
				end else begin
					rd_addr = c_q.base[IW-1:0];
					state_d = S_A_SKIP_CHK;
				end
			end

			S_A_SKIP_CHK: begin
				if (is_blocker(e.tag, purge_q)) begin
					c_d.base = c_q.base + ONE;
					state_d  = S_A_SKIP;
				end else begin
					c_d.space = BS_W'(e.len);
					c_d.r     = c_q.base + ONE;
					state_d   = S_A_RUN;
				end
			end

			S_A_RUN: begin
				if (c_q.space >= c_q.bs) begin
					state_d = S_A_BASE_RD;
				end else begin
					fin        = c_q.finish || (c_q.r == c_q.stop);
					c_d.finish = fin;
					if (c_q.r >= count_q) begin
						c_d.base = '0;
						if (fin) begin
							c_d.rst = ST_OOM;
							state_d = S_REPLY;
						end else begin
							state_d = S_A_SKIP;
						end
					end else begin
						rd_addr = c_q.r[IW-1:0];
						state_d = S_A_RUN_CHK;
					end
				end
			end

			S_A_RUN_CHK: begin
				if (is_blocker(e.tag, purge_q)) begin
					c_d.base = c_q.r + ONE;
					if (c_q.finish) begin
						c_d.rst = ST_OOM;
						state_d = S_REPLY;
					end else begin
						state_d = S_A_SKIP;
					end
				end else begin
					c_d.space = c_q.space + BS_W'(e.len);
					c_d.r     = c_q.r + ONE;
					state_d   = S_A_RUN;
				end
			end

			S_A_BASE_RD: begin
				rd_addr = c_q.base[IW-1:0];
				state_d = S_A_BASE_CHK;
			end

			S_A_BASE_CHK: begin
				if (e.tag != '0) begin
					c_d.note_own = e.owner;
					c_d.fi       = c_q.base;
					c_d.fret     = RET_PURGE;
					state_d      = S_NOTE;
				end else begin
					state_d = S_A_PL_RD;
				end
			end

			S_A_PL_RD: begin
				rd_addr = c_q.base[IW-1:0];
				state_d = S_A_PL_LEN;
			end

			S_A_PL_LEN: begin
				c_d.cur = e;
				if (BS_W'(e.len) < c_q.bs && c_q.base + ONE < count_q) begin
					rd_addr = IW'(c_q.base + ONE);
					state_d = S_A_PL_NXT;
				end else begin
					state_d = S_A_SET;
				end
			end

			S_A_PL_NXT: begin
				if (e.tag != '0) begin
					c_d.note_own = e.owner;
					c_d.fi       = c_q.base + ONE;
					c_d.fret     = RET_PURGE;
					state_d      = S_NOTE;
				end else begin
					state_d = S_A_SET;
				end
			end

			S_A_SET: begin
				e       = c_q.cur;
				e.tag   = (c_q.tag == '0) ? eff_sub(sub_q) : c_q.tag;
				e.owner = c_q.own;
				c_d.radr = e.start + ADDR_W'(HEADER_BYTES);
				if (BS_W'(e.len) >= c_q.bs) begin
					extra = LEN_W'(BS_W'(e.len) - c_q.bs);
				end
				wr_en   = 1'b1;
				wr_addr = c_q.base[IW-1:0];
				if (extra > LEN_W'(HEADER_BYTES) && count_q < CNT_MAX) begin
					// split off the tail as a new free block
					c_d.nent = '{start: e.start + ADDR_W'(c_q.bs), len: extra,
						tag: '0, owner: '0};
					e.len    = LEN_W'(c_q.bs);
					c_d.j    = c_q.base + ONE;
					c_d.ptr  = count_q;
					c_d.pend = 1'b0;
					state_d  = S_SH_UP;
				end else begin
					state_d = S_A_DONE;
				end
				wr_data = e;
			end

			S_A_DONE: begin
				rover_d = c_q.base + ONE;
				state_d = S_REPLY;
			end

			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign notice        = out_q.notice;
	assign cleared_owner = out_q.cleared_owner;
	assign data_address  = out_q.data_address;
	assign free_bytes    = out_q.free_bytes;
	assign cache_bytes   = out_q.cache_bytes;
	assign used_bytes    = out_q.used_bytes;
	assign largest_run   = out_q.largest_run;
	assign last          = out_q.last;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_MAX))
		else $error("block count out of range");

	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		rover_q <= count_q)
		else $error("rover beyond end of table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted an item while one is in progress");

	a_notice_vs_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (notice != last))
		else $error("result is both or neither notice and final reply");

endmodule
`default_nettype wire

@@ dv/zba_checker.sv @@
// Checker for the zone block allocator: mirrors the block table and compares every result item.
`timescale 1ns / 1ps
module zba_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [zba_pkg::ACT_W-1:0]     action,
	input  logic [zba_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [zba_pkg::TAG_W-1:0]     tag,
	input  logic [zba_pkg::TAG_W-1:0]     high_tag,
	input  logic [zba_pkg::OWN_W-1:0]     owner,
	input  logic [zba_pkg::ADDR_W-1:0]    address,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [zba_pkg::ST_W-1:0]      status,
	input  logic                          notice,
	input  logic [zba_pkg::OWN_W-1:0]     cleared_owner,
	input  logic [zba_pkg::ADDR_W-1:0]    data_address,
	input  logic [zba_pkg::LEN_W-1:0]     free_bytes,
	input  logic [zba_pkg::LEN_W-1:0]     cache_bytes,
	input  logic [zba_pkg::LEN_W-1:0]     used_bytes,
	input  logic [zba_pkg::LEN_W-1:0]     largest_run,
	input  logic                          last,
	input  logic                          cfg_write,
	input  logic [zba_pkg::CFG_I_W-1:0]   cfg_index,
	input  logic [zba_pkg::TAG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending_count,
	output logic [zba_pkg::ADDR_W-1:0]    live_addr
);
	import zba_pkg::*;

	localparam int NB = MAX_BLOCKS_DEF;

	longint unsigned bstart[NB];
	longint unsigned blen[NB];
	int unsigned     btag[NB];
	int unsigned     bown[NB];
	int unsigned     nblk;
	int unsigned     rover;
	int unsigned     purge_lvl;
	int unsigned     sub_tag;
	result_t         expected_q[$];
	int              nres;
	int unsigned     held_owner;

	function automatic result_t mk(int unsigned st, int unsigned nt, int unsigned ow,
			longint unsigned ad, longint unsigned fb, longint unsigned cb,
			longint unsigned ub, longint unsigned lr, int unsigned lst);
		result_t r;
		r.status = ST_W'(st);
		r.notice = nt[0];
		r.cleared_owner = OWN_W'(ow);
		r.data_address = ADDR_W'(ad);
		r.free_bytes = LEN_W'(fb);
		r.cache_bytes = LEN_W'(cb);
		r.used_bytes = LEN_W'(ub);
		r.largest_run = LEN_W'(lr);
		r.last = lst[0];
		return r;
	endfunction

	task automatic emit_notice(int unsigned ow);
		if (ow != 0) begin
			if (nres < 63) begin
				expected_q.push_back(mk(ST_OK, 1, ow, 0, 0, 0, 0, 0, 0));
				nres++;
			end else
				held_owner = ow;
		end
	endtask

	task automatic merge_down(int unsigned j);
		blen[j-1] += blen[j];
		for (int unsigned k = j; k + 1 < nblk; k++) begin
			bstart[k] = bstart[k+1];
			blen[k] = blen[k+1];
			btag[k] = btag[k+1];
			bown[k] = bown[k+1];
		end
		nblk--;
		if (rover >= j) rover--;
	endtask

	task automatic release_block(inout int unsigned i);
		btag[i] = 0;
		bown[i] = 0;
		if (i > 0 && btag[i-1] == 0) begin
			merge_down(i);
			i--;
		end
		if (i + 1 < nblk && btag[i+1] == 0) merge_down(i + 1);
	endtask

	function automatic bit blocks(int unsigned p);
		if (p >= nblk) return 1;
		return btag[p] != 0 && btag[p] < purge_lvl;
	endfunction

	function automatic int unsigned wrap_next(int unsigned p);
		return p >= nblk ? 0 : p + 1;
	endfunction

	function automatic int unsigned sub_eff();
		return sub_tag != 0 ? sub_tag : 1;
	endfunction

	task automatic predict_alloc(longint unsigned sz, int unsigned tg, int unsigned ow);
		longint unsigned need, space, extra;
		int unsigned base, stop, r, guard, t, j;
		bit done, found;
		need = ((sz + 3) & ~64'd3) + HEADER_BYTES;
		t = tg;
		guard = 0;
		done = 0;
		found = 0;
		if (t == 0)
			t = sub_eff();
		else if (t >= purge_lvl && ow == 0) begin
			expected_q.push_back(mk(ST_OWNER, 0, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		base = rover > nblk ? nblk : rover;
		if (base > 0 && btag[base-1] == 0) base--;
		stop = base == 0 ? nblk : base - 1;
		while (!found && guard++ < 4 * (NB + 2)) begin
			while (base != stop && blocks(base)) base = wrap_next(base);
			if (base == stop) break;
			space = blen[base];
			r = wrap_next(base);
			found = 1;
			while (space < need) begin
				if (r == stop) done = 1;
				if (blocks(r)) begin
					base = wrap_next(r);
					found = 0;
					break;
				end
				space += blen[r];
				r = wrap_next(r);
			end
			if (!found && done) break;
		end
		if (!found) begin
			expected_q.push_back(mk(ST_OOM, 0, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		if (btag[base] != 0) begin
			emit_notice(bown[base]);
			release_block(base);
		end
		while (blen[base] < need && base + 1 < nblk && btag[base+1] != 0) begin
			emit_notice(bown[base+1]);
			base = base + 1;
			release_block(base);
		end
		btag[base] = t;
		bown[base] = ow;
		extra = blen[base] >= need ? blen[base] - need : 0;
		if (extra > HEADER_BYTES && nblk < NB) begin
			j = base + 1;
			for (int unsigned k = nblk; k > j; k--) begin
				bstart[k] = bstart[k-1];
				blen[k] = blen[k-1];
				btag[k] = btag[k-1];
				bown[k] = bown[k-1];
			end
			nblk++;
			if (rover >= j) rover++;
			bstart[j] = bstart[base] + need;
			blen[j] = extra;
			btag[j] = 0;
			bown[j] = 0;
			blen[base] = need;
			release_block(j);
		end
		rover = base + 1;
		expected_q.push_back(mk(ST_OK, 0, held_owner, bstart[base] + HEADER_BYTES,
			0, 0, 0, 0, 1));
	endtask

	task automatic predict_item();
		int unsigned i, t, ow, lo, hi;
		longint unsigned fb, cb, ub, run, best;
		nres = 0;
		held_owner = 0;
		case (action)
			ACT_ALLOC: predict_alloc(size_bytes, tag, owner);
			ACT_FREE, ACT_CHANGE: begin
				i = nblk;
				for (int unsigned k = 0; k < nblk; k++)
					if (i == nblk && btag[k] != 0 && bstart[k] + HEADER_BYTES == address) i = k;
				if (i >= nblk)
					expected_q.push_back(mk(ST_BAD, 0, 0, 0, 0, 0, 0, 0, 1));
				else if (action == ACT_FREE) begin
					ow = bown[i];
					release_block(i);
					expected_q.push_back(mk(ST_OK, 0, ow, 0, 0, 0, 0, 0, 1));
				end else begin
					t = tag;
					if (t == 0) t = sub_eff();
					else if (t >= purge_lvl && bown[i] == 0) begin
						expected_q.push_back(mk(ST_OWNER, 0, 0, 0, 0, 0, 0, 0, 1));
						return;
					end
					btag[i] = t;
					expected_q.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
				end
			end
			ACT_RANGE: begin
				lo = tag;
				hi = high_tag;
				i = 0;
				while (i < nblk) begin
					t = btag[i];
					if (t != 0 && t >= lo && t <= hi) begin
						emit_notice(bown[i]);
						release_block(i);
						i++;
					end else
						i++;
				end
				expected_q.push_back(mk(ST_OK, 0, held_owner, 0, 0, 0, 0, 0, 1));
			end
			ACT_REPORT: begin
				fb = 0; cb = 0; ub = 0; run = 0; best = 0;
				for (int unsigned k = 0; k < nblk; k++) begin
					if (btag[k] == 0) begin
						fb += blen[k];
						run += blen[k];
					end else if (btag[k] >= purge_lvl) begin
						cb += blen[k];
						run += blen[k];
					end else begin
						ub += blen[k];
						run = 0;
					end
					if (run > best) best = run;
				end
				expected_q.push_back(mk(ST_OK, 0, 0, 0, fb, cb, ub, best, 1));
			end
			default: expected_q.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1));
		endcase
	endtask

	task automatic compare_result();
		result_t got, want;
		got = '{status, notice, cleared_owner, data_address, free_bytes, cache_bytes,
			used_bytes, largest_run, last};
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result item %h", $time, got);
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		if (got.status != want.status) begin
			$display("%0t: status exp %0d got %0d", $time, want.status, got.status); fail_count++;
		end
		if (got.notice != want.notice) begin
			$display("%0t: notice exp %0d got %0d", $time, want.notice, got.notice); fail_count++;
		end
		if (got.cleared_owner != want.cleared_owner) begin
			$display("%0t: cleared_owner exp %0d got %0d", $time, want.cleared_owner,
				got.cleared_owner);
			fail_count++;
		end
		if (got.data_address != want.data_address) begin
			$display("%0t: data_address exp %0d got %0d", $time, want.data_address,
				got.data_address);
			fail_count++;
		end
		if (got.free_bytes != want.free_bytes) begin
			$display("%0t: free_bytes exp %0d got %0d", $time, want.free_bytes, got.free_bytes);
			fail_count++;
		end
		if (got.cache_bytes != want.cache_bytes) begin
			$display("%0t: cache_bytes exp %0d got %0d", $time, want.cache_bytes,
				got.cache_bytes);
			fail_count++;
		end
		if (got.used_bytes != want.used_bytes) begin
			$display("%0t: used_bytes exp %0d got %0d", $time, want.used_bytes, got.used_bytes);
			fail_count++;
		end
		if (got.largest_run != want.largest_run) begin
			$display("%0t: largest_run exp %0d got %0d", $time, want.largest_run,
				got.largest_run);
			fail_count++;
		end
		if (got.last != want.last) begin
			$display("%0t: last exp %0d got %0d", $time, want.last, got.last); fail_count++;
		end
	endtask

	// hand the stimulus a live payload address now and then
	always_comb begin
		live_addr = '0;
		for (int k = 0; k < NB; k++)
			if (k < nblk && btag[k] != 0) live_addr = ADDR_W'(bstart[k] + HEADER_BYTES);
	end

	initial begin
		fail_count = 0;
		for (int k = 0; k < NB; k++) begin
			bstart[k] = 0; blen[k] = 0; btag[k] = 0; bown[k] = 0;
		end
		blen[0] = HEAP_BYTES;
		nblk = 1;
		rover = 0;
		purge_lvl = PURGE_RST;
		sub_tag = SUB_RST;
		pending_count = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) compare_result();
			if (cfg_write) begin
				if (cfg_index == CFG_PURGE) purge_lvl = cfg_data;
				else sub_tag = cfg_data;
			end
			if (in_valid && in_ready) predict_item();
			pending_count <= expected_q.size();
		end
	end
endmodule

@@ dv/zone_block_allocator_top_test.sv @@
// Testbench top for the zone block allocator: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module zone_block_allocator_top_test;
	import zba_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [ACT_W-1:0]   action;
	logic [SIZE_W-1:0]  size_bytes;
	logic [TAG_W-1:0]   tag;
	logic [TAG_W-1:0]   high_tag;
	logic [OWN_W-1:0]   owner;
	logic [ADDR_W-1:0]  address;
	logic               out_valid;
	logic               out_ready;
	logic [ST_W-1:0]    status;
	logic               notice;
	logic [OWN_W-1:0]   cleared_owner;
	logic [ADDR_W-1:0]  data_address;
	logic [LEN_W-1:0]   free_bytes;
	logic [LEN_W-1:0]   cache_bytes;
	logic [LEN_W-1:0]   used_bytes;
	logic [LEN_W-1:0]   largest_run;
	logic               last;
	logic               cfg_write;
	logic [CFG_I_W-1:0] cfg_index;
	logic [TAG_W-1:0]   cfg_data;
	int                 fail_count;
	int                 pending_count;
	logic [ADDR_W-1:0]  live_addr;
	int                 idle_cycles;
	bit                 long_hold;
	bit                 hold_done;

	zone_block_allocator_top DUT (.*);

	zba_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		out_ready = 0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				out_ready <= 0;
				for (n = 0; n < 3000; n++) @(posedge clk);
				hold_done = 1;
			end
			case ($urandom_range(0, 3))
				0: out_ready <= 0;
				default: out_ready <= 1;
			endcase
		end
	end

	// watchdog on accepted handshakes
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 200000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_item(logic [ACT_W-1:0] a, logic [SIZE_W-1:0] sz, logic [TAG_W-1:0] t,
			logic [TAG_W-1:0] ht, logic [OWN_W-1:0] ow, logic [ADDR_W-1:0] ad);
		action <= a;
		size_bytes <= sz;
		tag <= t;
		high_tag <= ht;
		owner <= ow;
		address <= ad;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_I_W-1:0] idx, logic [TAG_W-1:0] val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 0;
		@(posedge clk);
	endtask

	task automatic random_item();
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] ad;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: sz = SIZE_W'($urandom());
			1: sz = SIZE_W'($urandom_range(0, 4000000));
			default: sz = SIZE_W'($urandom_range(0, 300));
		endcase
		ad = ($urandom_range(0, 3) != 0) ? live_addr : ADDR_W'($urandom());
		if (pick < 45)
			send_item(ACT_ALLOC, sz, TAG_W'($urandom()), TAG_W'($urandom()),
				($urandom_range(0, 5) == 0) ? OWN_W'(0) : OWN_W'($urandom()), ad);
		else if (pick < 65)
			send_item(ACT_FREE, sz, TAG_W'($urandom()), 0, 0, ad);
		else if (pick < 78)
			send_item(ACT_CHANGE, 0, TAG_W'($urandom()), 0, 0, ad);
		else if (pick < 86)
			send_item(ACT_RANGE, 0, TAG_W'($urandom()), TAG_W'($urandom()), 0, 0);
		else if (pick < 96)
			send_item(ACT_REPORT, 0, 0, 0, 0, 0);
		else
			send_item(ACT_W'($urandom_range(5, 7)), SIZE_W'($urandom()), TAG_W'($urandom()),
				TAG_W'($urandom()), OWN_W'($urandom()), ADDR_W'($urandom()));
	endtask

	task automatic random_phase(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && count > 0) begin
				random_item();
				burst--;
				count--;
			end
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
	endtask

	initial begin
		in_valid = 0;
		action = '0;
		size_bytes = '0;
		tag = '0;
		high_tag = '0;
		owner = '0;
		address = '0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		long_hold = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed part
		send_item(ACT_REPORT, 0, 0, 0, 0, 0);
		send_item(ACT_ALLOC, 0, 0, 0, 0, 0);
		send_item(ACT_ALLOC, 100, 150, 0, 16'hFFFF, 0);
		send_item(ACT_ALLOC, 40, 200, 0, 0, 0);
		send_item(ACT_ALLOC, 50, 99, 0, 0, 0);
		send_item(ACT_ALLOC, SIZE_W'(HEAP_BYTES), 5, 0, 0, 0);
		send_item(ACT_ALLOC, 26'h3FFFFFF, 5, 0, 0, 0);
		send_item(ACT_CHANGE, 0, 0, 0, 0, 24);
		send_item(ACT_CHANGE, 0, 255, 0, 0, 24);
		send_item(ACT_CHANGE, 0, 7, 0, 0, 25'h1FFFFFF);
		send_item(ACT_FREE, 0, 0, 0, 0, 3);
		send_item(ACT_FREE, 0, 0, 0, 0, 24);
		send_item(ACT_ALLOC, 33000000, 120, 0, 16'h1234, 0);
		send_item(ACT_REPORT, 0, 0, 0, 0, 0);
		send_item(ACT_ALLOC, 20, 3, 0, 9, 0);
		send_item(ACT_RANGE, 0, 0, 255, 0, 0);
		send_item(3'd7, 26'h3FFFFFF, 8'hFF, 8'hFF, 16'hFFFF, 25'h1FFFFFF);
		send_item(ACT_REPORT, 0, 0, 0, 0, 0);
		drain();

		// fill the table with purgeable blocks with owners, then one large alloc, a report and a small alloc
		write_reg(CFG_PURGE, 8'd1);
		write_reg(CFG_SUB, 8'd0);
		for (int k = 0; k < 70; k++)
			send_item(ACT_ALLOC, SIZE_W'($urandom_range(0, 64)), TAG_W'($urandom_range(1, 255)),
				0, OWN_W'($urandom_range(1, 65535)), 0);
		send_item(ACT_ALLOC, 26'h1FF0000, 9, 0, 5, 0);
		send_item(ACT_REPORT, 0, 0, 0, 0, 0);
		send_item(ACT_ALLOC, 8, 0, 0, 0, 0);
		drain();

		write_reg(CFG_PURGE, 8'd255);
		write_reg(CFG_SUB, 8'd255);
		long_hold = 1;
		random_phase(40);
		drain();

		write_reg(CFG_PURGE, 8'd100);
		write_reg(CFG_SUB, 8'd1);
		random_phase(60);
		drain();

		write_reg(CFG_PURGE, 8'd20);
		write_reg(CFG_SUB, 8'd40);
		random_phase(60);
		send_item(ACT_RANGE, 0, 0, 255, 0, 0);
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
